>>> design/rwmsd_pkg.sv
// Package for the random walk mean-square-displacement accumulator.
// Holds the transaction structs, opcodes, register indexes and generator constants.
// No dependencies.
package rwmsd_pkg;

	// Table geometry and field widths
	localparam int MAX_STEPS = 1024;
	localparam int ADDR_W    = $clog2(MAX_STEPS);
	localparam int STEPS_W   = 11;
	localparam int SUM_W     = 48;
	localparam int CFG_W     = 64;

	// Opcodes of an input transaction
	localparam logic [1:0] OP_STEP   = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_RELOAD = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_STEPS       = 2'd0;
	localparam logic [1:0] CFG_SEED_MAIN   = 2'd1;
	localparam logic [1:0] CFG_SEED_SECOND = 2'd2;

	// Reset values of the configuration registers
	localparam logic [STEPS_W-1:0] STEPS_RESET = 11'd1000;
	localparam logic [63:0]        SEED_MAIN_RESET = 64'd1;
	localparam logic [47:0]        SEED_SECOND_RESET = 48'd1;

	// Power of the generator step carried through the generator pipeline
	localparam logic [1:0] PWR_1 = 2'd1;
	localparam logic [1:0] PWR_2 = 2'd2;
	localparam logic [1:0] PWR_3 = 2'd3;

	// Main generator: multiplicative, modulo 2^64, and its powers
	localparam logic [63:0] MAIN_MULT    = 64'd1181783497276652981;
	localparam logic [63:0] MAIN_MULT_P2 = MAIN_MULT * MAIN_MULT;
	localparam logic [63:0] MAIN_MULT_P3 = MAIN_MULT_P2 * MAIN_MULT;

	// Second generator: X = A*X + B modulo 2^48, folded for two and three steps
	localparam logic [47:0] SEC_MULT    = 48'h5DEECE66D;
	localparam logic [47:0] SEC_ADD     = 48'hB;
	localparam logic [47:0] SEC_MULT_P2 = SEC_MULT * SEC_MULT;
	localparam logic [47:0] SEC_MULT_P3 = SEC_MULT_P2 * SEC_MULT;
	localparam logic [47:0] SEC_ADD_P2  = SEC_MULT * SEC_ADD + SEC_ADD;
	localparam logic [47:0] SEC_ADD_P3  = SEC_MULT * SEC_ADD_P2 + SEC_ADD;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ADDR_W-1:0] read_index;
	} rwmsd_in_t;

	typedef struct packed {
		logic signed [10:0] position;
		logic [ADDR_W-1:0]  step_index;
		logic               trial_end;
		logic [31:0]        trials_done;
		logic [SUM_W-1:0]   sum_value;
		logic               overflow;
	} rwmsd_out_t;

	// Control of the generator ring
	typedef struct packed {
		logic       adv;
		logic       inject;
		logic [1:0] pwr;
	} rwmsd_ring_ctl_t;

	function automatic logic [63:0] main_mult(input logic [1:0] pwr);
		case (pwr)
			PWR_1: return MAIN_MULT;
			PWR_2: return MAIN_MULT_P2;
			PWR_3: return MAIN_MULT_P3;
			default: return MAIN_MULT_P3;
		endcase
	endfunction

	function automatic logic [47:0] sec_mult(input logic [1:0] pwr);
		case (pwr)
			PWR_1: return SEC_MULT;
			PWR_2: return SEC_MULT_P2;
			PWR_3: return SEC_MULT_P3;
			default: return SEC_MULT_P3;
		endcase
	endfunction

	function automatic logic [47:0] sec_add(input logic [1:0] pwr);
		case (pwr)
			PWR_1: return SEC_ADD;
			PWR_2: return SEC_ADD_P2;
			PWR_3: return SEC_ADD_P3;
			default: return SEC_ADD_P3;
		endcase
	endfunction

endpackage

>>> design/rwmsd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module rwmsd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/rwmsd_lcg_ring.sv
// Three-stage generator ring that yields one value pair of both generators per advance.
// Depends on rwmsd_pkg for the generator constants and the control struct.
module rwmsd_lcg_ring
	import rwmsd_pkg::*;
(
	input  logic            clk,
	input  rwmsd_ring_ctl_t ctl,
	input  logic [63:0]     seed_main,
	input  logic [47:0]     seed_second,
	output logic [63:0]     head_main,
	output logic [47:0]     head_second
);

	// The ring holds three consecutive generator values: the head and two values
	// still in the multiplier pipeline. Each pass multiplies by the third power,
	// so the head steps through the sequence one value per advance. Refilling
	// injects the seed three times with the first, second and third powers.
	logic [63:0] x_main;
	logic [47:0] x_sec;
	logic [1:0]  pwr_in;
	logic [63:0] coef_m0, coef_m1, coef_m2;
	logic [47:0] coef_s0, coef_s1, coef_s2;
	logic [63:0] pll_m, mid_m, cross_m;
	logic [47:0] pll_s, mid_s, cross_s;

	logic [63:0] pll_m_s1, pll_m_s2;
	logic [31:0] xlo_m_s1, xhi_m_s1, xlo_m_s2, mid_m_s2;
	logic [47:0] pll_s_s1, pll_s_s2;
	logic [23:0] xlo_s_s1, xhi_s_s1, xlo_s_s2, mid_s_s2;
	logic [1:0]  pwr_s1, pwr_s2;
	logic [63:0] head_main_q;
	logic [47:0] head_second_q;

	assign x_main  = ctl.inject ? seed_main : head_main_q;
	assign x_sec   = ctl.inject ? seed_second : head_second_q;
	assign pwr_in  = ctl.inject ? ctl.pwr : PWR_3;
	assign coef_m0 = main_mult(pwr_in);
	assign coef_m1 = main_mult(pwr_s1);
	assign coef_m2 = main_mult(pwr_s2);
	assign coef_s0 = sec_mult(pwr_in);
	assign coef_s1 = sec_mult(pwr_s1);
	assign coef_s2 = sec_mult(pwr_s2);

	// One partial product per stage: low by low, then the two cross terms.
	assign pll_m   = x_main[31:0] * coef_m0[31:0];
	assign mid_m   = xhi_m_s1 * coef_m1[31:0];
	assign cross_m = xlo_m_s2 * coef_m2[63:32];
	assign pll_s   = x_sec[23:0] * coef_s0[23:0];
	assign mid_s   = xhi_s_s1 * coef_s1[23:0];
	assign cross_s = xlo_s_s2 * coef_s2[47:24];

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			pll_m_s1      <= pll_m;
			xlo_m_s1      <= x_main[31:0];
			xhi_m_s1      <= x_main[63:32];
			pll_s_s1      <= pll_s;
			xlo_s_s1      <= x_sec[23:0];
			xhi_s_s1      <= x_sec[47:24];
			pwr_s1        <= pwr_in;
			pll_m_s2      <= pll_m_s1;
			xlo_m_s2      <= xlo_m_s1;
			mid_m_s2      <= mid_m[31:0];
			pll_s_s2      <= pll_s_s1;
			xlo_s_s2      <= xlo_s_s1;
			mid_s_s2      <= mid_s[23:0];
			pwr_s2        <= pwr_s1;
			head_main_q   <= pll_m_s2 + {mid_m_s2 + cross_m[31:0], 32'd0};
			head_second_q <= pll_s_s2 + {mid_s_s2 + cross_s[23:0], 24'd0} + sec_add(pwr_s2);
		end
	end

	assign head_main   = head_main_q;
	assign head_second = head_second_q;

endmodule

>>> design/random_walk_msd_accumulator_core.sv
// Random walk engine that accumulates squared positions per time slot. The block
// takes one transaction per clock cycle while the output is not stalled and no
// clearing or refill runs; each result is registered in stage one, then in the
// output register. The rate is set by the read-modify-write of the 1024-entry sum
// table, which does one read and one write per cycle, and back-to-back updates of
// one slot are forwarded. After reset a clearing pass writes zero to every entry,
// during which no item is taken. A reload refills the three-stage generator ring
// and holds off input while it runs. Configuration writes are taken in every cycle.
// Depends on rwmsd_pkg, rwmsd_ram and rwmsd_lcg_ring.
module random_walk_msd_accumulator_core
	import rwmsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rwmsd_in_t         in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rwmsd_out_t        out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam logic [1:0] PRIME_LEN = 2'd3;

	// Configuration registers
	logic [STEPS_W-1:0] steps_q;
	logic [63:0]        seed_main_q;
	logic [47:0]        seed_second_q;

	// Walk state
	logic signed [10:0] pos_q;
	logic [ADDR_W-1:0]  step_q;
	logic [31:0]        trials_q;
	logic               sat_q;

	// Table clearing and generator refill
	logic               clr_busy_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [1:0]         prime_cnt_q;
	logic [63:0]        prime_main_q;
	logic [47:0]        prime_second_q;
	logic               priming;
	rwmsd_ring_ctl_t    ring_ctl;
	logic [63:0]        head_main;
	logic [47:0]        head_second;

	// Pipeline stage one and output register
	logic               s1_valid_q;
	logic [1:0]         op_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic signed [10:0] pos_s1;
	logic               end_s1;
	logic [31:0]        trials_s1;
	logic               out_valid_q;
	rwmsd_out_t         out_q;

	// Forwarding of a write that coincides with the next read
	logic               fwd_hit_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	logic [SUM_W-1:0]   fwd_data_q;

	logic               s1_adv;
	logic               in_accept;
	logic               step_acc;
	logic               move_up;
	logic signed [10:0] pos_next;
	logic [STEPS_W-1:0] last_slot;
	logic               trial_done;
	logic [31:0]        trials_next;
	logic [ADDR_W-1:0]  raddr;
	logic [SUM_W-1:0]   rdata;
	logic [SUM_W-1:0]   old_sum;
	logic signed [21:0] sq_s;
	logic [SUM_W:0]     sum_wide;
	logic               sat_now;
	logic [SUM_W-1:0]   new_sum;
	logic               wr_step;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [SUM_W-1:0]   ram_wdata;
	rwmsd_out_t         res;

	// Handshake: stage one moves on when the output register is free or drained.
	assign priming   = prime_cnt_q != 2'd0;
	assign s1_adv    = !out_valid_q || out_ready;
	assign in_ready  = !clr_busy_q && !priming && (!s1_valid_q || s1_adv);
	assign in_accept = in_valid && in_ready;
	assign step_acc  = in_accept && (in_data.opcode == OP_STEP);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q       <= STEPS_RESET;
			seed_main_q   <= SEED_MAIN_RESET;
			seed_second_q <= SEED_SECOND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEPS:       steps_q       <= cfg_data[STEPS_W-1:0];
				CFG_SEED_MAIN:   seed_main_q   <= cfg_data[63:0];
				CFG_SEED_SECOND: seed_second_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// Generator ring, refilled from the seed snapshot after reset and on reload.
	always_comb begin
		ring_ctl.adv    = step_acc || priming;
		ring_ctl.inject = priming;
		case (prime_cnt_q)
			2'd3:    ring_ctl.pwr = PWR_1;
			2'd2:    ring_ctl.pwr = PWR_2;
			default: ring_ctl.pwr = PWR_3;
		endcase
	end

	rwmsd_lcg_ring u_ring (
		.clk         (clk),
		.ctl         (ring_ctl),
		.seed_main   (prime_main_q),
		.seed_second (prime_second_q),
		.head_main   (head_main),
		.head_second (head_second)
	);

	// Move decision and end-of-trial detection for a step.
	assign move_up  = head_main < {head_second, 16'd0};
	assign pos_next = move_up ? pos_q + 11'sd1 : pos_q - 11'sd1;

	always_comb begin
		if (steps_q < 11'd2) begin
			last_slot = 11'd1;
		end else if (steps_q > STEPS_W'(MAX_STEPS)) begin
			last_slot = STEPS_W'(MAX_STEPS - 1);
		end else begin
			last_slot = steps_q - 11'd1;
		end
	end

	assign trial_done  = {1'b0, step_q} >= last_slot;
	assign trials_next = (trial_done && (trials_q != '1)) ? trials_q + 32'd1 : trials_q;

	// Walk state, refill control and the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			step_q         <= ADDR_W'(1);
			trials_q       <= '0;
			clr_busy_q     <= 1'b1;
			clr_addr_q     <= '0;
			prime_cnt_q    <= PRIME_LEN;
			prime_main_q   <= SEED_MAIN_RESET;
			prime_second_q <= SEED_SECOND_RESET;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_W'(MAX_STEPS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (priming) begin
				prime_cnt_q <= prime_cnt_q - 2'd1;
			end
			if (step_acc) begin
				trials_q <= trials_next;
				if (trial_done) begin
					pos_q  <= '0;
					step_q <= ADDR_W'(1);
				end else begin
					pos_q  <= pos_next;
					step_q <= step_q + ADDR_W'(1);
				end
			end else if (in_accept && (in_data.opcode == OP_RELOAD)) begin
				pos_q          <= '0;
				step_q         <= ADDR_W'(1);
				prime_cnt_q    <= PRIME_LEN;
				prime_main_q   <= seed_main_q;
				prime_second_q <= seed_second_q;
			end
		end
	end

	// Sum table: read on acceptance, written back from stage one.
	assign raddr = (in_data.opcode == OP_STEP) ? step_q : in_data.read_index;

	rwmsd_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_STEPS)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Stage one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1     <= in_data.opcode;
			addr_s1   <= raddr;
			end_s1    <= step_acc && trial_done;
			trials_s1 <= step_acc ? trials_next : trials_q;
			if (step_acc) begin
				pos_s1 <= pos_next;
			end else if (in_data.opcode == OP_READ) begin
				pos_s1 <= pos_q;
			end else if (in_data.opcode == OP_RELOAD) begin
				pos_s1 <= '0;
			end else begin
				pos_s1 <= pos_q;
			end
		end
	end

	// Saturating accumulate, with the previous write forwarded on an address match.
	assign old_sum  = (fwd_hit_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata;
	assign sq_s     = pos_s1 * pos_s1;
	assign sum_wide = {1'b0, old_sum} + {{(SUM_W - 21){1'b0}}, sq_s[21:0]};
	assign sat_now  = sum_wide[SUM_W];
	assign new_sum  = sat_now ? '1 : sum_wide[SUM_W-1:0];
	assign wr_step  = s1_valid_q && s1_adv && (op_s1 == OP_STEP);

	assign ram_we    = clr_busy_q || wr_step;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : new_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
			sat_q     <= 1'b0;
		end else begin
			if (in_accept) begin
				fwd_hit_q <= wr_step;
			end
			if (wr_step && sat_now) begin
				sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_sum;
		end
	end

	// Result of the transaction in stage one
	always_comb begin
		res.position    = pos_s1;
		res.step_index  = '0;
		res.trial_end   = 1'b0;
		res.trials_done = trials_s1;
		res.sum_value   = '0;
		res.overflow    = sat_q;
		case (op_s1)
			OP_STEP: begin
				res.step_index = addr_s1;
				res.trial_end  = end_s1;
				res.sum_value  = new_sum;
				res.overflow   = sat_q || sat_now;
			end
			OP_READ: begin
				res.sum_value = old_sum;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The clearing pass owns the write port; no step may write during it.
	assert property (@(posedge clk) disable iff (!arst_n) clr_busy_q |-> !wr_step)
		else $error("step write during the clearing pass");

	// A reload restarts the generator refill in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (in_data.opcode == OP_RELOAD)) |=> (prime_cnt_q == PRIME_LEN))
		else $error("reload did not start the generator refill");

	// The completed trial count never goes down.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (trials_q >= $past(trials_q)))
		else $error("trial count decreased");

	// The walk never reaches slot zero and stays within the table's reach.
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0) && (pos_q != 11'sh400))
		else $error("walk state out of range");

endmodule

>>> test/random_walk_msd_accumulator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for random_walk_msd_accumulator_core: a scoreboard class predicts
// every result of the walk, and plain tasks drive commands and register writes.
// Depends on rwmsd_pkg and the core with its submodules.
module random_walk_msd_accumulator_core_tb;
	import rwmsd_pkg::*;

	// Generator constants and limits used by the prediction
	localparam logic [63:0] WALK_MULT_MAIN   = 64'd1181783497276652981;
	localparam logic [47:0] WALK_MULT_SECOND = 48'h5DEECE66D;
	localparam logic [47:0] WALK_ADD_SECOND  = 48'hB;
	localparam logic [63:0] SUM_CEILING      = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [1:0]  OP_UNUSED        = 2'd3;
	localparam logic [1:0]  CFG_UNMAPPED     = 2'd3;
	localparam int          LONG_HOLD_CYCLES = 400;
	localparam int          DRAIN_SLACK      = 8;
	localparam int          WATCHDOG_LIMIT   = 5000;

	// Predicts the walk and compares each result with the oldest prediction.
	class msd_scoreboard;
		rwmsd_out_t expected_reports[$];
		logic [10:0] cfg_steps;
		logic [63:0] cfg_seed_main;
		logic [47:0] cfg_seed_second;
		logic [63:0] main_gen;
		logic [47:0] second_gen;
		int walker;
		int slot_now;
		logic [31:0] trials;
		logic [47:0] slot_sums[MAX_STEPS];
		bit saturated;
		int errors, checked, n_steps, n_reads, n_reloads, n_unused, n_trial_ends;

		function new();
			cfg_steps = 11'd1000;
			cfg_seed_main = 64'd1;
			cfg_seed_second = 48'd1;
			main_gen = 64'd1;
			second_gen = 48'd1;
			walker = 0;
			slot_now = 1;
			trials = '0;
			saturated = 1'b0;
			foreach (slot_sums[i]) slot_sums[i] = '0;
			errors = 0;
			checked = 0;
			n_steps = 0;
			n_reads = 0;
			n_reloads = 0;
			n_unused = 0;
			n_trial_ends = 0;
		endfunction

		function void write_register(logic [1:0] index, logic [63:0] data);
			case (index)
				CFG_STEPS: begin
					cfg_steps = data[10:0];
				end
				CFG_SEED_MAIN: begin
					cfg_seed_main = data;
				end
				CFG_SEED_SECOND: begin
					cfg_seed_second = data[47:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Last slot of a trial, with the register clamped to the table.
		function int final_slot();
			int n;
			n = cfg_steps;
			if (n < 2) n = 2;
			if (n > MAX_STEPS) n = MAX_STEPS;
			return n - 1;
		endfunction

		function void note_command(rwmsd_in_t cmd);
			rwmsd_out_t rep;
			logic [63:0] sq, total;
			int slot;
			bit trial_over;
			rep = '0;
			slot = slot_now;
			trial_over = 1'b0;
			case (cmd.opcode)
				OP_STEP: begin
					n_steps++;
					main_gen = main_gen * WALK_MULT_MAIN;
					second_gen = second_gen * WALK_MULT_SECOND + WALK_ADD_SECOND;
					// Up when the main fraction lies below the second one.
					if (main_gen < {second_gen, 16'h0000}) walker++;
					else walker--;
					sq = 64'(walker * walker);
					total = {16'h0000, slot_sums[slot]} + sq;
					if (total > SUM_CEILING) begin
						total = SUM_CEILING;
						saturated = 1'b1;
					end
					slot_sums[slot] = total[47:0];
					trial_over = (slot >= final_slot());
					if (trial_over) begin
						n_trial_ends++;
						if (trials != '1) trials++;
					end
					rep.step_index = slot[ADDR_W-1:0];
					rep.trial_end = trial_over;
					rep.sum_value = total[47:0];
				end
				OP_READ: begin
					n_reads++;
					rep.sum_value = slot_sums[cmd.read_index];
				end
				OP_RELOAD: begin
					n_reloads++;
					main_gen = cfg_seed_main;
					second_gen = cfg_seed_second;
					walker = 0;
					slot_now = 1;
				end
				default: begin
					n_unused++;
				end
			endcase
			rep.position = walker[10:0];
			rep.trials_done = trials;
			rep.overflow = saturated;
			expected_reports.push_back(rep);
			// A finished trial reports its final position, then the walk restarts.
			if (cmd.opcode == OP_STEP) begin
				if (trial_over) begin
					walker = 0;
					slot_now = 1;
				end else begin
					slot_now = slot + 1;
				end
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_report(rwmsd_out_t got);
			rwmsd_out_t want;
			checked++;
			if (expected_reports.size() == 0) begin
				$error("result with no transaction waiting: 0x%0h", got);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			compare_field("position", want.position, got.position);
			compare_field("step_index", want.step_index, got.step_index);
			compare_field("trial_end", want.trial_end, got.trial_end);
			compare_field("trials_done", want.trials_done, got.trials_done);
			compare_field("sum_value", want.sum_value, got.sum_value);
			compare_field("overflow", want.overflow, got.overflow);
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	rwmsd_in_t        in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	rwmsd_out_t       out_data;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	msd_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit long_hold_req = 1'b0;
	int quiet_cycles = 0;

	random_walk_msd_accumulator_core DUT (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register writes and transactions seen at the edge feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_register(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_command(in_data);
			if (out_valid && out_ready) sb.check_report(out_data);
		end
	end

	// Receiver: random stalls, and on request one long hold-off.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offers one command and returns at the edge where it is accepted.
	task automatic send_command(input logic [1:0] opcode, input logic [ADDR_W-1:0] index);
		rwmsd_in_t cmd;
		cmd.opcode = opcode;
		cmd.read_index = index;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= cmd;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
	endtask

	// Stops offering and waits until every predicted result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic load_register(input logic [1:0] index, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Slot count in the low bits, random junk above them.
	function automatic logic [63:0] with_noise(input int n);
		return {32'($urandom), 21'($urandom), 11'(n)};
	endfunction

	// One random phase: new settings, an idling mode and a mix of commands.
	task automatic run_random_phase(input logic [63:0] steps_word, input logic [63:0] seed_a,
			input logic [63:0] seed_b, input int send_idle, input int recv_stall,
			input int count, input int step_pct, input int reload_pct, input bit with_hold);
		int pick;
		logic [1:0] op;
		logic [ADDR_W-1:0] index;
		load_register(CFG_STEPS, steps_word);
		load_register(CFG_SEED_MAIN, seed_a);
		load_register(CFG_SEED_SECOND, seed_b);
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		if (with_hold) long_hold_req = 1'b1;
		repeat (count) begin
			pick = $urandom_range(99);
			index = ADDR_W'($urandom);
			if (pick < step_pct) begin
				op = OP_STEP;
			end else if (pick < step_pct + reload_pct) begin
				op = OP_RELOAD;
			end else if (pick % 5 == 0) begin
				op = OP_UNUSED;
			end else begin
				op = OP_READ;
				// Reads favor the slots that short trials actually fill.
				if ($urandom_range(1)) index = ADDR_W'($urandom_range(63));
			end
			send_command(op, index);
		end
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: table extremes, the unused opcode, steps and a reload.
		send_command(OP_READ, '0);
		send_command(OP_READ, '1);
		send_command(OP_UNUSED, 10'h2AA);
		repeat (4) send_command(OP_STEP, '1);
		send_command(OP_READ, 10'd2);
		send_command(OP_RELOAD, 10'h155);
		send_command(OP_STEP, '0);
		send_command(OP_READ, 10'd1);
		wait_drained();

		// Slot count below the minimum, zero main seed, all-ones second seed.
		// The first step falls past the new last slot and must end the trial.
		load_register(CFG_STEPS, with_noise(0));
		load_register(CFG_SEED_MAIN, '0);
		load_register(CFG_SEED_SECOND, '1);
		load_register(CFG_UNMAPPED, {32'($urandom), 32'($urandom)});
		send_command(OP_STEP, '0);
		send_command(OP_RELOAD, '0);
		repeat (3) send_command(OP_STEP, '0);
		send_command(OP_READ, 10'd1);
		wait_drained();

		// Slot count of one, all-ones main seed, zero second seed.
		load_register(CFG_STEPS, with_noise(1));
		load_register(CFG_SEED_MAIN, '1);
		load_register(CFG_SEED_SECOND, '0);
		send_command(OP_RELOAD, '1);
		repeat (3) send_command(OP_STEP, '1);
		send_command(OP_UNUSED, '0);
		wait_drained();

		// Random phases over the idling modes and slot counts up to the full table.
		run_random_phase(with_noise($urandom_range(3, 40)), {32'($urandom), 32'($urandom)},
			{32'($urandom), 32'($urandom)}, 0, 0, 250, 70, 5, 1'b1);
		run_random_phase(with_noise(2), {32'($urandom), 32'($urandom)},
			{32'($urandom), 32'($urandom)}, 52, 0, 200, 70, 5, 1'b0);
		run_random_phase(with_noise(MAX_STEPS), {32'($urandom), 32'($urandom)},
			{32'($urandom), 32'($urandom)}, 8, 8, 1100, 97, 0, 1'b0);
		run_random_phase(with_noise(2047), {32'($urandom), 32'($urandom)},
			{32'($urandom), 32'($urandom)}, 0, 52, 200, 70, 5, 1'b0);
		run_random_phase(with_noise($urandom_range(4, 60)), {32'($urandom), 32'($urandom)},
			{32'($urandom), 32'($urandom)}, 8, 8, 250, 75, 5, 1'b0);

		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		$display("Walk covered %0d steps, %0d reads, %0d reloads, %0d unused-opcode commands.",
			sb.n_steps, sb.n_reads, sb.n_reloads, sb.n_unused);
		$display("%0d trials finished; %0d results compared field by field.",
			sb.n_trial_ends, sb.checked);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
